// File: rtl/delimited_signed_field_frame_parser_unit_defines.svh
// Assertion macros shared by the frame parser checker
`ifndef DELIMITED_SIGNED_FIELD_FRAME_PARSER_UNIT_DEFINES_SVH
`define DELIMITED_SIGNED_FIELD_FRAME_PARSER_UNIT_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define DSFP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dsfp check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define DSFP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dsfp check failed");

`endif

// File: rtl/dsfp_pkg.sv
// Shared constants and types of the delimited signed field frame parser
`timescale 1ns / 1ps

package dsfp_pkg;

    localparam logic [7:0] CH_START = 8'h24;
    localparam logic [7:0] CH_SEP   = 8'h2C;
    localparam logic [7:0] CH_END   = 8'h26;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] MAX_FIELDS = 3'd4;

    localparam logic [2:0] IDX_DISTANCE    = 3'd0;
    localparam logic [2:0] IDX_DIRECTION   = 3'd1;
    localparam logic [2:0] IDX_ORIENTATION = 3'd2;
    localparam logic [2:0] IDX_FLAG        = 3'd3;

    typedef struct packed {
        logic [7:0] distance;
        logic [7:0] direction;
        logic [7:0] orientation;
        logic       leaving_flag;
        logic [2:0] fields_seen;
    } t_result;

endpackage

// File: rtl/dsfp_parse.sv
// Byte parser: frame state, field accumulator and held field values
`timescale 1ns / 1ps

module dsfp_parse
    import dsfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    logic       r_in_frame, n_in_frame;
    logic [2:0] r_field_index, n_field_index;
    logic [7:0] r_accum, n_accum;
    logic       r_is_negative, n_is_negative;
    logic       r_digits_started, n_digits_started;
    logic       r_digits_stopped, n_digits_stopped;
    logic [7:0] r_held_distance, n_held_distance;
    logic [7:0] r_held_direction, n_held_direction;
    logic [7:0] r_held_orientation, n_held_orientation;
    logic       r_held_flag, n_held_flag;

    logic       is_digit;
    logic [7:0] digit_value;
    logic [7:0] accum_times_ten;
    logic [7:0] field_value;
    logic [2:0] index_after_store;
    logic       do_store;

    assign is_digit        = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit_value     = i_rx_byte - CH_ZERO;
    assign accum_times_ten = {r_accum[4:0], 3'b000} + {r_accum[6:0], 1'b0};
    assign field_value     = r_is_negative ? (8'd0 - r_accum) : r_accum;
    assign index_after_store = (r_field_index < MAX_FIELDS) ? (r_field_index + 3'd1)
                                                            : r_field_index;
    assign do_store = i_accept && r_in_frame
                   && ((i_rx_byte == CH_SEP) || (i_rx_byte == CH_END));

    always_comb begin
        n_in_frame         = r_in_frame;
        n_field_index      = r_field_index;
        n_accum            = r_accum;
        n_is_negative      = r_is_negative;
        n_digits_started   = r_digits_started;
        n_digits_stopped   = r_digits_stopped;
        n_held_distance    = r_held_distance;
        n_held_direction   = r_held_direction;
        n_held_orientation = r_held_orientation;
        n_held_flag        = r_held_flag;
        o_res_valid        = 1'b0;

        if (do_store) begin
            unique case (r_field_index)
                IDX_DISTANCE:    n_held_distance    = field_value;
                IDX_DIRECTION:   n_held_direction   = field_value;
                IDX_ORIENTATION: n_held_orientation = field_value;
                IDX_FLAG:        n_held_flag        = (field_value != 8'd0);
                default: ;
            endcase
        end

        if (i_accept) begin
            priority if (i_rx_byte == CH_START) begin
                n_in_frame       = 1'b1;
                n_field_index    = 3'd0;
                n_accum          = 8'd0;
                n_is_negative    = 1'b0;
                n_digits_started = 1'b0;
                n_digits_stopped = 1'b0;
            end else if (!r_in_frame) begin
            end else if ((i_rx_byte == CH_SEP) || (i_rx_byte == CH_END)) begin
                n_field_index    = index_after_store;
                n_accum          = 8'd0;
                n_is_negative    = 1'b0;
                n_digits_started = 1'b0;
                n_digits_stopped = 1'b0;
                if (i_rx_byte == CH_END) begin
                    n_in_frame    = 1'b0;
                    n_field_index = 3'd0;
                    o_res_valid   = 1'b1;
                end
            end else if (r_digits_stopped) begin
            end else if (is_digit) begin
                n_accum          = accum_times_ten + digit_value;
                n_digits_started = 1'b1;
            end else if ((i_rx_byte == CH_MINUS) && !r_digits_started && !r_is_negative) begin
                n_is_negative = 1'b1;
            end else begin
                n_digits_stopped = 1'b1;
            end
        end

        o_res.distance     = n_held_distance;
        o_res.direction    = n_held_direction;
        o_res.orientation  = n_held_orientation;
        o_res.leaving_flag = n_held_flag;
        o_res.fields_seen  = index_after_store;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame         <= 1'b0;
            r_field_index      <= 3'd0;
            r_accum            <= 8'd0;
            r_is_negative      <= 1'b0;
            r_digits_started   <= 1'b0;
            r_digits_stopped   <= 1'b0;
            r_held_distance    <= 8'd0;
            r_held_direction   <= 8'd0;
            r_held_orientation <= 8'd0;
            r_held_flag        <= 1'b0;
        end else begin
            r_in_frame         <= n_in_frame;
            r_field_index      <= n_field_index;
            r_accum            <= n_accum;
            r_is_negative      <= n_is_negative;
            r_digits_started   <= n_digits_started;
            r_digits_stopped   <= n_digits_stopped;
            r_held_distance    <= n_held_distance;
            r_held_direction   <= n_held_direction;
            r_held_orientation <= n_held_orientation;
            r_held_flag        <= n_held_flag;
        end
    end

endmodule

// File: rtl/dsfp_out.sv
// Result register with a skid stage toward the output channel
`timescale 1ns / 1ps

module dsfp_out
    import dsfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_res_valid,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    logic    r_skid_valid;
    t_result r_res;
    t_result r_skid;
    logic    take;

    assign take    = r_valid && !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_full  = r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (take) begin
                r_valid      <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_valid || take) begin
            r_valid <= i_res_valid;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_res <= r_skid;
            end
        end else if (!r_valid || take) begin
            if (i_res_valid) begin
                r_res <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

// File: rtl/delimited_signed_field_frame_parser_unit.sv
// Top level of the delimited signed field frame parser
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   input   | in        | i_valid / o_stall  | i_rx_byte
//   output  | out       | o_valid / i_stall  | o_distance o_direction o_orientation
//           |           |                    | o_leaving_flag o_fields_seen
//
// One byte per cycle while o_stall is low; a frame's result is registered on its '&'.
// The byte update (multiply by ten, add digit, compares) sits before one state register.
// Reset is synchronous, active low, and clears frame state and held values to zero.
// A stalled result holds in the output register; one more result fits in the skid
// stage, and o_stall rises only while that stage is occupied.
`timescale 1ns / 1ps

module delimited_signed_field_frame_parser_unit
    import dsfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [7:0]        o_distance,
    output logic signed [7:0] o_direction,
    output logic signed [7:0] o_orientation,
    output logic              o_leaving_flag,
    output logic [2:0]        o_fields_seen
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    out_full;

    assign accept  = i_valid && !o_stall;
    assign o_stall = out_full;

    dsfp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dsfp_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_stall     (i_stall),
        .o_full      (out_full),
        .o_valid     (o_valid),
        .o_res       (out_res)
    );

    assign o_distance     = out_res.distance;
    assign o_direction    = $signed(out_res.direction);
    assign o_orientation  = $signed(out_res.orientation);
    assign o_leaving_flag = out_res.leaving_flag;
    assign o_fields_seen  = out_res.fields_seen;

endmodule

// File: rtl/dsfp_checker.sv
// Port-level checks of the frame parser and their bind to the top level
`timescale 1ns / 1ps
`include "delimited_signed_field_frame_parser_unit_defines.svh"

module dsfp_checker
    import dsfp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [7:0]        i_rx_byte,
    input logic              o_valid,
    input logic              i_stall,
    input logic [7:0]        o_distance,
    input logic signed [7:0] o_direction,
    input logic signed [7:0] o_orientation,
    input logic              o_leaving_flag,
    input logic [2:0]        o_fields_seen
);

    logic [27:0] out_bus;
    logic        end_taken;

    assign out_bus   = {o_distance, o_direction, o_orientation, o_leaving_flag, o_fields_seen};
    assign end_taken = i_valid && !o_stall && (i_rx_byte == CH_END);

    `DSFP_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(out_bus))
    `DSFP_ASSERT_NOW(a_count_range, o_valid, o_fields_seen <= MAX_FIELDS)
    `DSFP_ASSERT_NOW(a_stall_needs_result, o_stall, o_valid)
    `DSFP_ASSERT_NEXT(a_no_spurious, !o_valid && !end_taken, !o_valid)

endmodule

bind delimited_signed_field_frame_parser_unit dsfp_checker u_dsfp_checker (.*);
